FILE: hdl/bdlp_pkg.sv
package bdlp_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int DEB_W = 10;
	localparam int LONG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CODE_W = $clog2(NUM_BUTTONS + 2);
	localparam int CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;
	localparam int SELECT_INDEX = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);
	localparam logic [LONG_W-1:0] LONG_PRESS_RESET = LONG_W'(1000);

	localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_LONG_SELECT = CODE_W'(NUM_BUTTONS + 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
	} lane_evt_t;

endpackage

FILE: hdl/bdlp_lane.sv
module bdlp_lane import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              raw_bit,
	input  logic [DEB_W-1:0]  debounce_ms,
	input  logic [LONG_W-1:0] long_limit,
	output lane_evt_t         evt
);

	logic   last_q;
	logic   stable_q;
	logic   mark_q;
	count_t sc_q;
	count_t pc_q;

	count_t sc_d;
	count_t pc_d;
	logic   stable_d;
	logic   mark_d;
	logic   accepted;

	always_comb begin
		evt = '0;
		sc_d = (raw_bit != last_q) ? '0 : ((sc_q == '1) ? sc_q : sc_q + 1'b1);
		pc_d = pc_q;
		if (!stable_q) begin
			pc_d = (pc_q == '1) ? pc_q : pc_q + 1'b1;
		end
		stable_d = stable_q;
		mark_d = mark_q;
		accepted = CMP_W'(sc_d) > CMP_W'(debounce_ms);
		if (accepted) begin
			if (!raw_bit) begin
				if (stable_q) begin
					stable_d = 1'b0;
					pc_d = '0;
					mark_d = 1'b0;
				end
				if (!mark_d && (CMP_W'(pc_d) > CMP_W'(long_limit))) begin
					mark_d = 1'b1;
					evt.long_hit = 1'b1;
				end
			end else if (!stable_q) begin
				stable_d = 1'b1;
				evt.short_hit = !mark_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
			stable_q <= 1'b1;
			mark_q <= 1'b0;
			sc_q <= '0;
			pc_q <= '0;
		end else if (en) begin
			last_q <= raw_bit;
			stable_q <= stable_d;
			mark_q <= mark_d;
			sc_q <= sc_d;
			pc_q <= pc_d;
		end
	end

endmodule

FILE: hdl/bdlp_merge.sv
module bdlp_merge import bdlp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   out_ready,
	input  lane_evt_t              evts [NUM_BUTTONS],
	output logic                   out_valid,
	output logic [CODE_W-1:0]      event_code
);

	logic [NUM_BUTTONS-1:0] pend_short_q;
	logic                   pend_long_q;
	logic                   out_valid_q;
	logic [CODE_W-1:0]      code_q;

	logic [NUM_BUTTONS-1:0] short_all;
	logic [NUM_BUTTONS-1:0] short_d;
	logic                   long_all;
	logic                   long_d;
	logic [CODE_W-1:0]      code_d;
	logic                   found;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			short_all[i] = pend_short_q[i] | evts[i].short_hit;
		end
		long_all = pend_long_q | evts[SELECT_INDEX].long_hit;
		short_d = short_all;
		long_d = long_all;
		code_d = CODE_NONE;
		found = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (!found && short_all[i]) begin
				found = 1'b1;
				short_d[i] = 1'b0;
				code_d = CODE_W'(i + 1);
			end
		end
		if (!found && long_all) begin
			long_d = 1'b0;
			code_d = CODE_LONG_SELECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_short_q <= '0;
			pend_long_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			pend_short_q <= short_d;
			pend_long_q <= long_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_q <= code_d;
		end
	end

	assign out_valid = out_valid_q;
	assign event_code = code_q;

endmodule

FILE: hdl/button_debounce_long_press.sv
// Four-button debouncer with short and long press events.
// Input channel (in_valid/in_ready, raw_levels): one transaction per millisecond
// tick; raw_levels is active low, bit0 up, bit1 down, bit2 select, bit3 back.
// Output channel (out_valid/out_ready, event_code): exactly one transaction per
// input transaction; 0 none, 1..4 short press of up/down/select/back,
// 5 long press of select. Lowest pending code goes out first, others wait.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// the debounce window (low 10 bits), index 1 sets the long-press limit; other
// indexes are dropped. cfg_ready is always high; write only while idle.
// The result is in the output register in the cycle after the input
// transaction. One tick per cycle is taken while the receiver keeps up, with
// the per-button counters of all four lanes updated in parallel.
// A stalled receiver holds the output register; in_ready then drops until the
// result is taken, so no tick is lost or merged.
// Reset: levels released, counters and pending events cleared, debounce
// window 50 and long-press limit 1000.
module button_debounce_long_press import bdlp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [NUM_BUTTONS-1:0] raw_levels,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CODE_W-1:0]      event_code,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [DEB_W-1:0]  debounce_q;
	logic [LONG_W-1:0] long_press_q;
	logic              accept;
	lane_evt_t         evts [NUM_BUTTONS];

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DEBOUNCE) begin
				debounce_q <= cfg_data[DEB_W-1:0];
			end else if (cfg_index == REG_LONG_PRESS) begin
				long_press_q <= cfg_data[LONG_W-1:0];
			end
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bdlp_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (accept),
			.raw_bit     (raw_levels[g]),
			.debounce_ms (debounce_q),
			.long_limit  (long_press_q),
			.evt         (evts[g])
		);
	end

	bdlp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.out_ready  (out_ready),
		.evts       (evts),
		.out_valid  (out_valid),
		.event_code (event_code)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("no result after input transaction");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= CODE_LONG_SELECT))
		else $error("event code out of range");

	a_cfg_debounce: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == REG_DEBOUNCE) |=> (debounce_q == $past(cfg_data[DEB_W-1:0])))
		else $error("debounce register not written");

endmodule

FILE: dv/bdlp_event_checker.sv
module bdlp_event_checker import bdlp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [NUM_BUTTONS-1:0] raw_levels,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [CODE_W-1:0]      event_code,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     waiting
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [DEB_W-1:0]       deb_lim;
	logic [LONG_W-1:0]      long_lim;
	logic [NUM_BUTTONS-1:0] prev_raw;
	logic [NUM_BUTTONS-1:0] settled;
	count_t                 stab_cnt [NUM_BUTTONS];
	count_t                 dur_cnt [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] long_seen;
	logic [NUM_BUTTONS-1:0] short_due;
	logic                   long_sel_due;
	logic [CODE_W-1:0]      codes_due [$];
	logic [CODE_W-1:0]      want;

	function automatic logic [CODE_W-1:0] advance_tick(input logic [NUM_BUTTONS-1:0] raw);
		logic [CODE_W-1:0] code;
		int b;
		code = CODE_NONE;
		for (b = 0; b < NUM_BUTTONS; b++) begin
			if (raw[b] != prev_raw[b])
				stab_cnt[b] = '0;
			else if (stab_cnt[b] != '1)
				stab_cnt[b] = stab_cnt[b] + 1'b1;
			prev_raw[b] = raw[b];
			if (!settled[b] && dur_cnt[b] != '1)
				dur_cnt[b] = dur_cnt[b] + 1'b1;
			if (stab_cnt[b] > deb_lim) begin
				if (!raw[b]) begin
					if (settled[b]) begin
						settled[b] = 1'b0;
						dur_cnt[b] = '0;
						long_seen[b] = 1'b0;
					end
					if (!long_seen[b] && dur_cnt[b] > long_lim) begin
						long_seen[b] = 1'b1;
						if (b == SELECT_INDEX)
							long_sel_due = 1'b1;
					end
				end else if (!settled[b]) begin
					settled[b] = 1'b1;
					if (!long_seen[b])
						short_due[b] = 1'b1;
				end
			end
		end
		// lowest pending code goes out, the rest stay queued
		for (b = 0; b < NUM_BUTTONS; b++) begin
			if (code == CODE_NONE && short_due[b]) begin
				short_due[b] = 1'b0;
				code = CODE_W'(b + 1);
			end
		end
		if (code == CODE_NONE && long_sel_due) begin
			long_sel_due = 1'b0;
			code = CODE_LONG_SELECT;
		end
		return code;
	endfunction

	task automatic note_mismatch(input string what, input logic [CODE_W-1:0] exp_code,
			input logic [CODE_W-1:0] got_code);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: %s: expected event_code %0d, got %0d", $realtime, what, exp_code,
				got_code);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_lim = DEBOUNCE_RESET;
			long_lim = LONG_PRESS_RESET;
			prev_raw = '1;
			settled = '1;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				stab_cnt[b] = '0;
				dur_cnt[b] = '0;
			end
			long_seen = '0;
			short_due = '0;
			long_sel_due = 1'b0;
			codes_due.delete();
			mismatches = 0;
			waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE: begin
						deb_lim = cfg_data[DEB_W-1:0];
					end
					REG_LONG_PRESS: begin
						long_lim = cfg_data[LONG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (codes_due.size() == 0) begin
					note_mismatch("transaction with nothing pending", 'x, event_code);
				end else begin
					want = codes_due.pop_front();
					if (event_code !== want)
						note_mismatch("event_code mismatch", want, event_code);
				end
			end
			if (in_valid && in_ready)
				codes_due.push_back(advance_tick(raw_levels));
			waiting = codes_due.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top import bdlp_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 4;
	localparam int RANDOM_ITEMS = 1450;
	localparam int PRESSURE_CYCLES = 400;
	localparam realtime TIMEOUT = 8ms;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [NUM_BUTTONS-1:0] raw_levels = '1;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CODE_W-1:0]      event_code;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     mismatches;
	int                     waiting;

	int                     idle_odds = 0;
	logic                   squeeze = 1'b0;
	logic                   squeeze_done = 1'b0;
	logic [NUM_BUTTONS-1:0] cur_lvl = '1;
	int                     items_sent = 0;
	int                     random_base;
	int                     phase_end;
	int                     phase;
	int                     deb;
	int                     lng;

	button_debounce_long_press dut (.*);

	bdlp_event_checker chk (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic push_tick(input logic [NUM_BUTTONS-1:0] lvl);
		int gap;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_levels <= lvl;
		cur_lvl = lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic hold_level(input logic [NUM_BUTTONS-1:0] lvl, input int ticks);
		repeat (ticks) push_tick(lvl);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(input int deb_val, input int long_val);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] word [3];
		int k;
		idx[0] = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
		word[0] = CFG_DATA_W'($urandom);
		idx[1] = REG_DEBOUNCE;
		word[1] = CFG_DATA_W'($urandom);
		word[1][DEB_W-1:0] = DEB_W'(deb_val);
		idx[2] = REG_LONG_PRESS;
		word[2] = CFG_DATA_W'(long_val);
		for (k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= word[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one level change: optional noise, optional bounce, then a hold sized
	// around the debounce and long-press thresholds
	task automatic gesture(input int deb_val, input int long_val);
		logic [NUM_BUTTONS-1:0] target;
		logic [NUM_BUTTONS-1:0] flip;
		int len;
		int reach;
		reach = deb_val + 1;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 6)) push_tick(NUM_BUTTONS'($urandom));
		if ($urandom_range(0, 1))
			flip = NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1);
		else
			flip = NUM_BUTTONS'($urandom_range(1, (1 << NUM_BUTTONS) - 1));
		target = cur_lvl ^ flip;
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) push_tick(target ^ (flip & NUM_BUTTONS'($urandom)));
		case ($urandom_range(0, 4))
			0: len = $urandom_range(1, reach);
			1: len = reach + $urandom_range(1, 3);
			2: len = reach + long_val + $urandom_range(0, 4);
			default: len = $urandom_range(1, 2 * (reach + long_val) + 4);
		endcase
		if (len > 400)
			len = 400;
		hold_level(target, len);
	endtask

	always begin : out_side
		@(posedge clk);
		if (squeeze && !squeeze_done) begin
			squeeze_done = 1'b1;
			out_ready <= 1'b0;
			repeat (PRESSURE_CYCLES) @(posedge clk);
			out_ready <= 1'b1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#TIMEOUT;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: debounce window 0, long press one tick after acceptance
		wait_idle();
		program_regs(0, 0);
		idle_odds = 6;
		hold_level(4'b1111, 2);
		hold_level(4'b0000, 3);
		hold_level(4'b1111, 3);
		hold_level(4'b1110, 2);
		hold_level(4'b1111, 2);
		hold_level(4'b0000, 2);
		hold_level(4'b1111, 4);
		hold_level(4'b0101, 1);
		hold_level(4'b1010, 1);
		hold_level(4'b0101, 1);
		hold_level(4'b1010, 1);

		random_base = items_sent;
		phase = 0;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			case (phase % 6)
				0: begin deb = 0; lng = 1; end
				1: begin deb = 1; lng = 4; end
				2: begin deb = 3; lng = 12; end
				3: begin deb = $urandom_range(0, 6); lng = $urandom_range(1, 40); end
				4: begin deb = 2; lng = 65535; end
				default: begin deb = $urandom_range(0, 3); lng = $urandom_range(1, 8); end
			endcase
			wait_idle();
			program_regs(deb, lng);
			case ($urandom_range(0, 3))
				0: idle_odds = 0;
				1: idle_odds = 2;
				2: idle_odds = 6;
				default: idle_odds = 15;
			endcase
			if (phase == 2)
				squeeze <= 1'b1;
			phase_end = items_sent + $urandom_range(120, 220);
			while (items_sent < phase_end)
				gesture(deb, lng);
			phase++;
		end

		// widest debounce window: short holds must never be accepted
		wait_idle();
		program_regs(1023, 1);
		idle_odds = 10;
		hold_level(4'b1010, 30);
		hold_level(4'b1111, 10);

		wait_idle();
		program_regs(1, 6);
		idle_odds = 0;
		phase_end = items_sent + 150;
		while (items_sent < phase_end)
			gesture(1, 6);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
hdl/bdlp_pkg.sv
hdl/bdlp_lane.sv
hdl/bdlp_merge.sv
hdl/button_debounce_long_press.sv
dv/bdlp_event_checker.sv
dv/tb_top.sv
